@@ hdl/dsh_pkg.sv @@
`default_nettype none

package dsh_pkg;

   // Default sizes of the block.
   localparam int DSH_MAX_BINS    = 64;
   localparam int DSH_COUNT_WIDTH = 20;
   localparam int DSH_FRAC_BITS   = 16;

   // Fixed field widths.
   localparam int DSH_FIELD_WIDTH = 16;
   localparam int DSH_MAXD_WIDTH  = 7;
   localparam int DSH_INDEX_WIDTH = 6;

   // Register reset values.
   localparam logic [DSH_MAXD_WIDTH-1:0]         DSH_MAX_DELAY_RESET = 7'd64;
   localparam logic signed [DSH_FIELD_WIDTH-1:0] DSH_MIN_ONSET_RESET = 16'sd0;

   // Register index, taken from paddr[2].
   localparam logic DSH_REG_MAX_DELAY = 1'b0;
   localparam logic DSH_REG_MIN_ONSET = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_WR,
      ST_EMIT_RD,
      ST_EMIT_ACC,
      ST_EMIT_SETUP,
      ST_EMIT_DIV,
      ST_EMIT_OUT,
      ST_CLEAR
   } dsh_state_type;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } dsh_div_stat_type;

endpackage

`default_nettype wire

@@ hdl/dsh_ram.sv @@
`default_nettype none

module dsh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/dsh_div.sv @@
`default_nettype none

module dsh_div
   import dsh_pkg::*;
#(
   parameter int CW = DSH_COUNT_WIDTH,
   parameter int FB = DSH_FRAC_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CW-1:0]    numer,
   input  wire logic [CW-1:0]    denom,
   output dsh_div_stat_type      stat,
   output logic      [FB:0]      quotient
);

   localparam int SW = $clog2(FB + 2);

   logic [CW:0]   rem_ff,  rem_in;
   logic [CW-1:0] den_ff,  den_in;
   logic [FB:0]   quot_ff, quot_in;
   logic [SW-1:0] step_ff, step_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic          ge;
   logic [CW:0]   diff;
   logic [CW:0]   kept_rem;

   // One restoring shift-subtract step per cycle; numer is at most denom,
   // so the quotient has one integer bit and FB fraction bits.
   always_comb begin
      ge       = rem_ff >= {1'b0, den_ff};
      diff     = rem_ff - {1'b0, den_ff};
      kept_rem = ge ? diff : rem_ff;

      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = {1'b0, numer};
         den_in  = denom;
         quot_in = '0;
         step_in = SW'(FB + 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {kept_rem[CW-1:0], 1'b0};
         quot_in = {quot_ff[FB-1:0], ge};
         step_in = step_ff - SW'(1);
         if (step_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

`default_nettype wire

@@ hdl/delay_survival_histogram.sv @@
`default_nettype none

// Channel   Direction  Handshake                       Payload
// request   in         start & !busy                   req_delay, req_onset_time,
//                                                      req_last_record
// response  out        rsp_strobe (one cycle, no hold) rsp_bin_index,
//                                                      rsp_remaining_fraction,
//                                                      rsp_no_data, rsp_last_result
// config    in         psel & penable & pwrite         paddr, pwdata, prdata, pready
//
// A record that goes into no bin is handled in ST_IDLE alone; a binned record
// also passes ST_LOAD_WR (read-modify-write of the bin memory).
// In the emit run each bin passes ST_EMIT_RD, ST_EMIT_ACC and ST_EMIT_SETUP,
// then ST_EMIT_DIV on the shared shift-subtract divider unless it has no data
// or nothing remaining, and ST_EMIT_OUT. The run ends by clearing the histogram.
// Reset is synchronous; it clears the counters and the bin valid bits at once.
// busy is high while a record or an emit run is in progress; results cannot be
// stalled and each beat is on the rsp_ ports for exactly one cycle.

module delay_survival_histogram
   import dsh_pkg::*;
#(
   parameter int MAX_BINS    = DSH_MAX_BINS,
   parameter int COUNT_WIDTH = DSH_COUNT_WIDTH,
   parameter int FRAC_BITS   = DSH_FRAC_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel.
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [DSH_FIELD_WIDTH-1:0] req_delay,
   input  wire logic signed [DSH_FIELD_WIDTH-1:0] req_onset_time,
   input  wire logic                              req_last_record,
   // Response channel.
   output logic                                   rsp_strobe,
   output logic      [DSH_INDEX_WIDTH-1:0]        rsp_bin_index,
   output logic      [FRAC_BITS:0]                rsp_remaining_fraction,
   output logic                                   rsp_no_data,
   output logic                                   rsp_last_result,
   // Configuration port.
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [2:0]                        paddr,
   input  wire logic [31:0]                       pwdata,
   output logic      [31:0]                       prdata,
   output logic                                   pready
);

   localparam int AW = $clog2(MAX_BINS > 1 ? MAX_BINS : 2);
   localparam int MW = $clog2(MAX_BINS + 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Configuration registers.
   logic [DSH_MAXD_WIDTH-1:0]         max_delay_ff;
   logic signed [DSH_FIELD_WIDTH-1:0] min_onset_ff;

   // Sequencer and datapath registers.
   dsh_state_type          state_ff, state_in;
   logic [COUNT_WIDTH-1:0] kept_ff, kept_in;
   logic [COUNT_WIDTH-1:0] sum_ff, sum_in;
   logic [MW-1:0]          idx_ff, idx_in;
   logic                   last_ff, last_in;
   logic [AW-1:0]          bin_addr_ff, bin_addr_in;
   logic [FRAC_BITS:0]     frac_ff, frac_in;
   logic                   nd_ff, nd_in;
   logic                   rd_valid_ff;
   logic [MAX_BINS-1:0]    valid_ff, valid_in;

   // Control from the output decoder.
   logic accept;
   logic ram_wr_en;
   logic div_start;
   logic do_clear;

   // Combinational datapath terms.
   logic [MW-1:0]          eff_max;
   logic signed [31:0]     delay_ext;
   logic signed [31:0]     max_ext;
   logic                   keep;
   logic                   to_bin;
   logic [AW-1:0]          rd_addr;
   logic [COUNT_WIDTH-1:0] ram_rd_data;
   logic [COUNT_WIDTH-1:0] bin_val;
   logic [COUNT_WIDTH-1:0] bin_inc;
   logic [COUNT_WIDTH:0]   sum_wide;
   logic                   idx_last;
   logic                   cfg_wr;
   logic [31:0]            delay_m1;
   logic [MW-1:0]          emit_pos;

   dsh_div_stat_type       div_stat;
   logic [FRAC_BITS:0]     div_quot;

   // Effective bin count: max_delay limited to the number of bins.
   always_comb begin
      if (32'(max_delay_ff) > 32'(MAX_BINS)) begin
         eff_max = MW'(MAX_BINS);
      end else begin
         eff_max = MW'(max_delay_ff);
      end
   end

   // Keep test and bin address of an incoming record.
   always_comb begin
      delay_ext = 32'(req_delay);
      max_ext   = signed'(32'(eff_max));
      keep      = (delay_ext <= max_ext) && (req_onset_time >= min_onset_ff);
      to_bin    = keep && (delay_ext >= 32'sd1);
      delay_m1  = 32'(delay_ext - 32'sd1);
      emit_pos  = eff_max - MW'(1) - idx_ff;
      idx_last  = (idx_ff == eff_max - MW'(1));
   end

   // Memory read address: the record's bin while idle, the walk position later.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_addr = delay_m1[AW-1:0];
      end else begin
         rd_addr = emit_pos[AW-1:0];
      end
   end

   // Bin value read back, zero when the entry holds nothing since the last clear.
   always_comb begin
      bin_val  = rd_valid_ff ? ram_rd_data : '0;
      bin_inc  = (bin_val == COUNT_MAX) ? COUNT_MAX : bin_val + COUNT_WIDTH'(1);
      sum_wide = {1'b0, sum_ff} + {1'b0, bin_val};
   end

   dsh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (bin_addr_ff),
      .wr_data (bin_inc),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   dsh_div #(
      .CW (COUNT_WIDTH),
      .FB (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (kept_ff - sum_ff),
      .denom    (kept_ff),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (to_bin) begin
                  state_in = ST_LOAD_WR;
               end else if (req_last_record) begin
                  state_in = (eff_max == '0) ? ST_CLEAR : ST_EMIT_RD;
               end
            end
         end
         ST_LOAD_WR: begin
            if (last_ff) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_ACC;
         end
         ST_EMIT_ACC: begin
            state_in = ST_EMIT_SETUP;
         end
         ST_EMIT_SETUP: begin
            if ((kept_ff == '0) || (sum_ff >= kept_ff)) begin
               state_in = ST_EMIT_OUT;
            end else begin
               state_in = ST_EMIT_DIV;
            end
         end
         ST_EMIT_DIV: begin
            if (div_stat.done) begin
               state_in = ST_EMIT_OUT;
            end
         end
         ST_EMIT_OUT: begin
            state_in = idx_last ? ST_CLEAR : ST_EMIT_RD;
         end
         ST_CLEAR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      accept     = 1'b0;
      ram_wr_en  = 1'b0;
      div_start  = 1'b0;
      do_clear   = 1'b0;
      rsp_strobe = 1'b0;
      busy       = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            accept = start;
         end
         ST_LOAD_WR: begin
            ram_wr_en = 1'b1;
         end
         ST_EMIT_SETUP: begin
            div_start = (kept_ff != '0) && (sum_ff < kept_ff);
         end
         ST_EMIT_OUT: begin
            rsp_strobe = 1'b1;
         end
         ST_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      kept_in     = kept_ff;
      sum_in      = sum_ff;
      idx_in      = idx_ff;
      last_in     = last_ff;
      bin_addr_in = bin_addr_ff;
      frac_in     = frac_ff;
      nd_in       = nd_ff;
      valid_in    = valid_ff;

      // Count a kept record and remember where its bin is.
      if (accept) begin
         last_in     = req_last_record;
         bin_addr_in = delay_m1[AW-1:0];
         if (keep) begin
            kept_in = (kept_ff == COUNT_MAX) ? COUNT_MAX : kept_ff + COUNT_WIDTH'(1);
         end
      end

      if (ram_wr_en) begin
         valid_in[bin_addr_ff] = 1'b1;
      end

      // Accumulate the walked bins with saturation.
      if (state_ff == ST_EMIT_ACC) begin
         sum_in = sum_wide[COUNT_WIDTH] ? COUNT_MAX : sum_wide[COUNT_WIDTH-1:0];
      end

      // Results that need no division.
      if (state_ff == ST_EMIT_SETUP) begin
         nd_in   = (kept_ff == '0);
         frac_in = '0;
      end

      if ((state_ff == ST_EMIT_DIV) && div_stat.done) begin
         frac_in = div_quot;
      end

      if (rsp_strobe) begin
         idx_in = idx_ff + MW'(1);
      end

      // End of the run: empty histogram and counters.
      if (do_clear) begin
         kept_in  = '0;
         sum_in   = '0;
         idx_in   = '0;
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kept_ff  <= '0;
         sum_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kept_ff  <= kept_in;
         sum_ff   <= sum_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
      bin_addr_ff <= bin_addr_in;
      frac_ff     <= frac_in;
      nd_ff       <= nd_in;
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // Result fields.
   assign rsp_bin_index          = DSH_INDEX_WIDTH'(idx_ff);
   assign rsp_remaining_fraction = frac_ff;
   assign rsp_no_data            = nd_ff;
   assign rsp_last_result        = idx_last;

   // Configuration port.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_delay_ff <= DSH_MAX_DELAY_RESET;
         min_onset_ff <= DSH_MIN_ONSET_RESET;
      end else if (cfg_wr) begin
         case (paddr[2])
            DSH_REG_MAX_DELAY: max_delay_ff <= pwdata[DSH_MAXD_WIDTH-1:0];
            DSH_REG_MIN_ONSET: min_onset_ff <= signed'(pwdata[DSH_FIELD_WIDTH-1:0]);
            default: max_delay_ff <= max_delay_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         DSH_REG_MAX_DELAY: prdata = 32'(max_delay_ff);
         DSH_REG_MIN_ONSET: prdata = 32'(min_onset_ff);
         default:           prdata = '0;
      endcase
   end

`ifndef SYNTHESIS
   // The divider only runs while the sequencer waits for it.
   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_EMIT_DIV))
      else $error("divider busy outside its wait state");

   // The last beat of a run is followed by the histogram clear.
   a_last_then_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_result) |=> (state_ff == ST_CLEAR))
      else $error("run end not followed by clear");

   // A fraction never exceeds one.
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_remaining_fraction <= {1'b1, {FRAC_BITS{1'b0}}}))
      else $error("remaining fraction above one");

   // No data means a zero fraction.
   a_no_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_no_data) |-> (rsp_remaining_fraction == '0))
      else $error("fraction nonzero with no data");

   // A record that needs a bin write or starts an emit holds the block for
   // the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (to_bin || req_last_record)) |=> busy)
      else $error("block not busy after accepting a record");
`endif

endmodule

`default_nettype wire
